@@ design/backend_latency_ewma_circuit_breaker_top_macros.svh @@
// Assertion macros for the backend latency tracker.
// Used by backend_latency_ewma_circuit_breaker_top; needs clk and arst_n in scope.
`ifndef BACKEND_LATENCY_EWMA_CIRCUIT_BREAKER_TOP_MACROS_SVH
`define BACKEND_LATENCY_EWMA_CIRCUIT_BREAKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BLECB_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BLECB_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define BLECB_CHECK(lbl, prop, msg)
`define BLECB_IMPLY(lbl, ante, cons, msg)
`endif

`endif

@@ design/blecb_pkg.sv @@
// Shared types and constants for the backend latency tracker.
// No dependencies.
package blecb_pkg;

	localparam int ID_W    = 13;
	localparam int SLOTS   = 1 << ID_W;
	localparam int STAMP_W = 64;
	localparam int CNT_W   = 64;
	localparam int RUN_W   = 32;
	localparam int THR_W   = 16;

	// EWMA weight 7/8: new = (old * 7 + gap) >> 3
	localparam int AVG_SHIFT = 3;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

	// one table entry per backend
	typedef struct packed {
		logic               valid;
		logic               brk;
		logic [CNT_W-1:0]   avg;
		logic [STAMP_W-1:0] last;
		logic [CNT_W-1:0]   req;
		logic [CNT_W-1:0]   err;
		logic [RUN_W-1:0]   run;
	} entry_t;

	// per-word controls handed to the update datapath
	typedef struct packed {
		logic               ld;
		logic               failed;
		logic [STAMP_W-1:0] now;
		logic [THR_W-1:0]   thr;
	} upd_ctl_t;

endpackage

@@ design/blecb_if.sv @@
// Channel interfaces: request words in, record words out.
// Depends on blecb_pkg.
interface blecb_req_if;
	logic                          valid;
	logic                          ready;
	logic [blecb_pkg::ID_W-1:0]    backend_id;
	logic [blecb_pkg::STAMP_W-1:0] now_ns;
	logic                          request_failed;

	modport source (output valid, output backend_id, output now_ns, output request_failed,
		input ready);
	modport sink (input valid, input backend_id, input now_ns, input request_failed,
		output ready);
endinterface

interface blecb_rec_if;
	logic                          valid;
	logic                          ready;
	logic [blecb_pkg::ID_W-1:0]    backend_out;
	logic [blecb_pkg::CNT_W-1:0]   latency_avg_ns;
	logic                          failed_out;
	logic [blecb_pkg::STAMP_W-1:0] stamp_out;
	logic                          breaker_state;
	logic [blecb_pkg::CNT_W-1:0]   request_total;
	logic [blecb_pkg::CNT_W-1:0]   error_total;

	modport source (output valid, output backend_out, output latency_avg_ns,
		output failed_out, output stamp_out, output breaker_state,
		output request_total, output error_total, input ready);
	modport sink (input valid, input backend_out, input latency_avg_ns,
		input failed_out, input stamp_out, input breaker_state,
		input request_total, input error_total, output ready);
endinterface

@@ design/blecb_table.sv @@
// Per-backend state table: one synchronous RAM, registered read.
// Depends on blecb_pkg.
module blecb_table (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [blecb_pkg::ID_W-1:0] rd_addr,
	output blecb_pkg::entry_t          rd_data,
	input  logic                       wr_en,
	input  logic [blecb_pkg::ID_W-1:0] wr_addr,
	input  blecb_pkg::entry_t          wr_data
);

	blecb_pkg::entry_t mem_q [blecb_pkg::SLOTS];
	blecb_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/blecb_update.sv @@
// Two-step entry update: gap, scaled average and counters, then EWMA sum.
// Depends on blecb_pkg.
module blecb_update (
	input  logic                 clk,
	input  blecb_pkg::entry_t    rd_entry,
	input  blecb_pkg::upd_ctl_t  ctl,
	output blecb_pkg::entry_t    new_entry
);

	logic                              first_s1;
	logic                              brk_s1;
	logic                              ge_s1;
	logic [blecb_pkg::STAMP_W-1:0]     gap_s1;
	logic [blecb_pkg::CNT_W-1:0]       avg7_s1;
	logic [blecb_pkg::CNT_W-1:0]       req1_s1;
	logic [blecb_pkg::CNT_W-1:0]       err_s1;
	logic [blecb_pkg::CNT_W-1:0]       err1_s1;
	logic [blecb_pkg::RUN_W-1:0]       run1_s1;
	logic [blecb_pkg::RUN_W-1:0]       run1;
	logic [blecb_pkg::CNT_W-1:0]       sum;

	assign run1 = rd_entry.run + blecb_pkg::RUN_W'(1);

	// step 1: independent adds on the fetched entry
	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			first_s1 <= !rd_entry.valid;
			brk_s1   <= rd_entry.brk;
			gap_s1   <= ctl.now - rd_entry.last;
			// avg * 7 as (avg << 3) - avg, mod 2^64
			avg7_s1  <= (rd_entry.avg << blecb_pkg::AVG_SHIFT) - rd_entry.avg;
			req1_s1  <= rd_entry.req + blecb_pkg::CNT_W'(1);
			err_s1   <= rd_entry.err;
			err1_s1  <= rd_entry.err + blecb_pkg::CNT_W'(1);
			run1_s1  <= run1;
			ge_s1    <= run1 >= blecb_pkg::RUN_W'(ctl.thr);
		end
	end

	// step 2: EWMA sum and entry merge
	assign sum = avg7_s1 + gap_s1;

	always_comb begin
		new_entry.valid = 1'b1;
		new_entry.last  = ctl.now;
		if (first_s1) begin
			new_entry.brk = brk_s1;
			new_entry.avg = '0;
			new_entry.req = blecb_pkg::CNT_W'(1);
			new_entry.err = '0;
			new_entry.run = '0;
		end else begin
			new_entry.avg = sum >> blecb_pkg::AVG_SHIFT;
			new_entry.req = req1_s1;
			if (ctl.failed) begin
				new_entry.brk = brk_s1 | ge_s1;
				new_entry.err = err1_s1;
				new_entry.run = run1_s1;
			end else begin
				new_entry.brk = 1'b0;
				new_entry.err = err_s1;
				new_entry.run = '0;
			end
		end
	end

endmodule

@@ design/backend_latency_ewma_circuit_breaker_top.sv @@
// Top level of the backend latency tracker with per-backend circuit breaker.
// Depends on blecb_pkg, blecb_if, blecb_table, blecb_update and the macros header.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-------------------------------------------
//  req     | in  | valid/ready        | backend_id, now_ns, request_failed
//  rec     | out | valid/ready        | backend_out, latency_avg_ns, failed_out,
//          |     |                    | stamp_out, breaker_state, request_total,
//          |     |                    | error_total
//  cfg     | in  | cfg_we             | cfg_wdata -> trip threshold
//
// A request for a real backend passes through accept and table read, the
// first update step, then the EWMA sum with write-back into the output
// register, set by the registered table read plus the two-step update.
// A request for backend 0 is accepted but makes no update and no record.
// After reset, a clearing pass writes all 8192 table entries, one per cycle,
// with req.ready low; configuration writes are taken during it.
// A full output register holds the write-back step until rec.ready; the next
// request is still taken while a finished record waits.
`include "backend_latency_ewma_circuit_breaker_top_macros.svh"

module backend_latency_ewma_circuit_breaker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	blecb_req_if.sink                   req,
	blecb_rec_if.source                 rec,
	input  logic                        cfg_we,
	input  logic [blecb_pkg::THR_W-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_CALC  = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t                        state_q;
	state_t                        state_d;
	logic [blecb_pkg::ID_W-1:0]    clr_q;
	logic [blecb_pkg::THR_W-1:0]   thr_q;

	// request held for the duration of its update
	logic [blecb_pkg::ID_W-1:0]    id_q;
	logic [blecb_pkg::STAMP_W-1:0] now_q;
	logic                          failed_q;

	// output register
	logic                          out_valid_q;
	logic [blecb_pkg::ID_W-1:0]    out_id_q;
	logic [blecb_pkg::CNT_W-1:0]   out_avg_q;
	logic                          out_failed_q;
	logic [blecb_pkg::STAMP_W-1:0] out_stamp_q;
	logic                          out_brk_q;
	logic [blecb_pkg::CNT_W-1:0]   out_req_q;
	logic [blecb_pkg::CNT_W-1:0]   out_err_q;

	logic                          accept;
	logic                          wb_go;
	logic                          wr_en;
	logic [blecb_pkg::ID_W-1:0]    wr_addr;
	blecb_pkg::entry_t             wr_data;
	blecb_pkg::entry_t             rd_entry;
	blecb_pkg::entry_t             new_entry;
	blecb_pkg::upd_ctl_t           ctl;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid & req.ready;

	// write-back proceeds only when the output register can take the record
	assign wb_go = (state_q == ST_WRITE) && (!out_valid_q || rec.ready);

	// --- threshold register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= blecb_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// --- sequencer ---
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && req.backend_id != '0) state_d = ST_CALC;
			end
			ST_CALC: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (wb_go) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + blecb_pkg::ID_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q     <= req.backend_id;
			now_q    <= req.now_ns;
			failed_q <= req.request_failed;
		end
	end

	// --- table and update datapath ---
	// clearing pass writes zeros (entry invalid, breaker closed)
	assign wr_en   = (state_q == ST_CLEAR) || wb_go;
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : id_q;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : new_entry;

	assign ctl.ld     = (state_q == ST_CALC);
	assign ctl.failed = failed_q;
	assign ctl.now    = now_q;
	assign ctl.thr    = thr_q;

	blecb_table u_table (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (req.backend_id),
		.rd_data (rd_entry),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	blecb_update u_update (
		.clk       (clk),
		.rd_entry  (rd_entry),
		.ctl       (ctl),
		.new_entry (new_entry)
	);

	// --- output register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (rec.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			out_id_q     <= id_q;
			out_avg_q    <= new_entry.avg;
			out_failed_q <= failed_q;
			out_stamp_q  <= now_q;
			out_brk_q    <= new_entry.brk;
			out_req_q    <= new_entry.req;
			out_err_q    <= new_entry.err;
		end
	end

	assign rec.valid          = out_valid_q;
	assign rec.backend_out    = out_id_q;
	assign rec.latency_avg_ns = out_avg_q;
	assign rec.failed_out     = out_failed_q;
	assign rec.stamp_out      = out_stamp_q;
	assign rec.breaker_state  = out_brk_q;
	assign rec.request_total  = out_req_q;
	assign rec.error_total    = out_err_q;

	// --- assertions ---
	`BLECB_IMPLY(a_clear_blocks_req, state_q == ST_CLEAR, !req.ready, "request taken during clear")
	`BLECB_IMPLY(a_rec_from_wb, $rose(out_valid_q), $past(state_q == ST_WRITE), "record without write-back")
	`BLECB_CHECK(a_rec_id_nonzero, !rec.valid || rec.backend_out != '0, "record for backend zero")
	`BLECB_IMPLY(a_wb_single_write, wb_go, wr_en && wr_addr == id_q, "write-back to wrong entry")

endmodule
